/* rtl/core/hfdc_pkg.sv */
// Shared constants and result type for the half-float delta codec.
`default_nettype none

package hfdc_pkg;

	localparam int unsigned SINGLE_W = 32;
	localparam int unsigned HALF_W   = 16;

	localparam logic [HALF_W-1:0]   HALF_ZERO     = 16'h0000;
	localparam logic [HALF_W-1:0]   HALF_MAX      = 16'hffff;
	localparam logic [HALF_W-1:0]   DELTA_POS_MAX = 16'h7fff;
	localparam logic [HALF_W-1:0]   DELTA_NEG_MAX = 16'h8000;
	localparam logic [4:0]          HALF_EXP_MAX  = 5'h1f;
	localparam logic [7:0]          SINGLE_EXP_MAX = 8'hff;
	localparam logic [7:0]          EXP_FLUSH     = 8'd112;
	localparam logic [7:0]          EXP_OVERFLOW  = 8'd143;
	localparam logic [7:0]          EXP_REBIAS    = 8'd112;

	typedef struct packed {
		logic [HALF_W-1:0]   half_word;
		logic [HALF_W-1:0]   delta_out;
		logic [SINGLE_W-1:0] float_out;
		logic                clipped;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/hfdc_sample_if.sv */
// Input channel interface: valid/ready plus one input item.
`default_nettype none

interface hfdc_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] float_word;
	logic [15:0] delta_word;
	logic        first_item;

	modport source (output valid, output float_word, output delta_word, output first_item,
		input ready);
	modport sink (input valid, input float_word, input delta_word, input first_item,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/hfdc_result_if.sv */
// Output channel interface: valid/ready plus one result item.
`default_nettype none

interface hfdc_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] half_word;
	logic [15:0] delta_out;
	logic [31:0] float_out;
	logic        clipped;

	modport source (output valid, output half_word, output delta_out, output float_out,
		output clipped, input ready);
	modport sink (input valid, input half_word, input delta_out, input float_out,
		input clipped, output ready);
endinterface

`default_nettype wire

/* rtl/core/hfdc_encoder.sv */
// Encode path: float32 to truncated half, then saturated delta against the previous half.
`default_nettype none

module hfdc_encoder (
	input  logic [31:0]      float_word,
	input  logic             first_item,
	input  logic [15:0]      previous_half,
	output hfdc_pkg::result_t result
);
	import hfdc_pkg::*;

	logic             sign;
	logic [7:0]       bexp;
	logic [7:0]       rebased;
	logic [HALF_W-1:0] half;
	logic [HALF_W:0]  diff;

	assign sign    = float_word[31];
	assign bexp    = float_word[30:23];
	assign rebased = bexp - EXP_REBIAS;

	always_comb begin
		if (bexp <= EXP_FLUSH) begin
			half = {sign, 15'd0};
		end else if (bexp >= EXP_OVERFLOW) begin
			half = {sign, HALF_EXP_MAX, 10'd0};
		end else begin
			half = {sign, rebased[4:0], float_word[22:13]};
		end
	end

	// 17-bit signed difference; top two bits disagree on 16-bit overflow
	assign diff = {1'b0, half} - {1'b0, previous_half};

	always_comb begin
		result.half_word = half;
		result.float_out = '0;
		result.clipped   = 1'b0;
		if (first_item) begin
			result.delta_out = half;
		end else if (diff[HALF_W] != diff[HALF_W-1]) begin
			result.clipped   = 1'b1;
			result.delta_out = diff[HALF_W] ? DELTA_NEG_MAX : DELTA_POS_MAX;
		end else begin
			result.delta_out = diff[HALF_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/hfdc_decoder.sv */
// Decode path: clamped delta accumulation, then half to float32 expansion.
`default_nettype none

module hfdc_decoder (
	input  logic [15:0]      delta_word,
	input  logic             first_item,
	input  logic [15:0]      previous_half,
	output hfdc_pkg::result_t result
);
	import hfdc_pkg::*;

	logic [HALF_W+1:0] sum;
	logic [HALF_W-1:0] half;
	logic              clip;
	logic [4:0]        hexp;
	logic [9:0]        mant;
	logic [7:0]        sexp;

	assign sum = {2'b00, previous_half} + {{2{delta_word[HALF_W-1]}}, delta_word};

	always_comb begin
		clip = 1'b0;
		if (first_item) begin
			half = delta_word;
		end else if (sum[HALF_W+1]) begin
			half = HALF_ZERO;
			clip = 1'b1;
		end else if (sum[HALF_W]) begin
			half = HALF_MAX;
			clip = 1'b1;
		end else begin
			half = sum[HALF_W-1:0];
		end
	end

	assign hexp = half[14:10];
	assign mant = half[9:0];
	assign sexp = {3'b000, hexp} + EXP_REBIAS;

	always_comb begin
		result.half_word = half;
		result.delta_out = '0;
		result.clipped   = clip;
		if (hexp == 5'd0) begin
			// subnormal halves drop to positive zero
			result.float_out = (mant == 10'd0) ? {half[15], 31'd0} : '0;
		end else if (hexp == HALF_EXP_MAX) begin
			result.float_out = {half[15], SINGLE_EXP_MAX, mant, 13'd0};
		end else begin
			result.float_out = {half[15], sexp, mant, 13'd0};
		end
	end

endmodule

`default_nettype wire

/* rtl/core/half_float_delta_codec.sv */
// Top level of the half-float delta codec: input register, codec paths, result register.
`default_nettype none

// Streaming float32/half delta codec. One item is taken per clock while results are not
// stalled, and one result is produced per item. A transfer on samples lands in the input
// register; from there the encode or decode path (chosen by the direction register) forms
// the result, which loads the result register when that register is free or draining.
// Sustained rate is one item per clock, set by the feedback loop of the previous-half
// register through the 18-bit decode add and clamp or the 17-bit encode subtract and
// saturation. The input register keeps accepting while a finished result waits, as long
// as that result leaves the same cycle; with results stalled, one item is held in the
// input register and one in the result register. Write direction (cfg_we/cfg_data, 0
// encode, 1 decode) only when no item is in flight. The previous half value is shared by
// both directions, starts at zero after reset, and carries across a change of direction.
module half_float_delta_codec (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_data,
	hfdc_sample_if.sink    samples,
	hfdc_result_if.source  results
);
	import hfdc_pkg::*;

	logic              direction_q;
	logic [HALF_W-1:0] previous_half_q;

	logic              valid_s1;
	logic [31:0]       float_word_s1;
	logic [15:0]       delta_word_s1;
	logic              first_item_s1;

	logic              valid_s2;
	result_t           result_s2;

	result_t           enc_result;
	result_t           dec_result;
	result_t           next_result;
	logic              advance;

	// advance the held item whenever the result register is free or draining
	assign advance       = valid_s1 && (!valid_s2 || results.ready);
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (cfg_we) begin
			direction_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	// hold the payload until it advances
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			float_word_s1 <= samples.float_word;
			delta_word_s1 <= samples.delta_word;
			first_item_s1 <= samples.first_item;
		end
	end

	hfdc_encoder u_encoder (
		.float_word    (float_word_s1),
		.first_item    (first_item_s1),
		.previous_half (previous_half_q),
		.result        (enc_result)
	);

	hfdc_decoder u_decoder (
		.delta_word    (delta_word_s1),
		.first_item    (first_item_s1),
		.previous_half (previous_half_q),
		.result        (dec_result)
	);

	assign next_result = direction_q ? dec_result : enc_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_half_q <= '0;
		end else if (advance) begin
			previous_half_q <= next_result.half_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || results.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= next_result;
		end
	end

	assign results.valid     = valid_s2;
	assign results.half_word = result_s2.half_word;
	assign results.delta_out = result_s2.delta_out;
	assign results.float_out = result_s2.float_out;
	assign results.clipped   = result_s2.clipped;

endmodule

`default_nettype wire

/* rtl/core/hfdc_checker.sv */
// Port-level checker for the half-float delta codec and its bind.
`default_nettype none

module hfdc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] out_half,
	input  logic [15:0] out_delta,
	input  logic [31:0] out_float,
	input  logic        out_clipped
);
	import hfdc_pkg::*;

	logic dir_q;

	// track the direction register from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
		end else if (cfg_we) begin
			dir_q <= cfg_data;
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_encode_no_float: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dir_q |-> out_float == '0)
		else $error("encode result carries a float word");

	a_decode_no_delta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dir_q |-> out_delta == '0)
		else $error("decode result carries a delta code");

	a_encode_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dir_q && out_clipped |->
			(out_delta == DELTA_POS_MAX || out_delta == DELTA_NEG_MAX))
		else $error("encode clip without a saturated delta");

	a_decode_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dir_q && out_clipped |->
			(out_half == HALF_ZERO || out_half == HALF_MAX))
		else $error("decode clip without a clamped half");

endmodule

bind half_float_delta_codec hfdc_checker u_hfdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_we      (cfg_we),
	.cfg_data    (cfg_data),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_half    (results.half_word),
	.out_delta   (results.delta_out),
	.out_float   (results.float_out),
	.out_clipped (results.clipped)
);

`default_nettype wire
